/* rtl/toeq_pkg.sv */
// Shared types and codes for the time-ordered event queue.
`default_nettype none

package toeq_pkg;

  // Request codes on req_type.
  localparam logic REQ_POST    = 1'b0;
  localparam logic REQ_CONSUME = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    RESP_POSTED   = 2'd0,
    RESP_FULL     = 2'd1,
    RESP_RELEASED = 2'd2,
    RESP_NONE_DUE = 2'd3
  } resp_t;

  // Controller states.
  typedef enum logic {
    S_IDLE    = 1'b0,
    S_RELEASE = 1'b1
  } state_t;

  // Command broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/toeq_cell.sv */
// One cell of the sorted chain: holds one event and trades it with its neighbors.
`default_nettype none

module toeq_cell
  import toeq_pkg::*;
#(
  parameter int TIME_BITS   = 32,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cell_cmd_t              cmd,
  input  wire logic [TIME_BITS-1:0]   new_time,
  input  wire logic [2:0]             new_kind,
  input  wire logic [HANDLE_BITS-1:0] new_handle,
  input  wire logic                   left_gt,
  input  wire logic                   left_valid,
  input  wire logic [TIME_BITS-1:0]   left_time,
  input  wire logic [2:0]             left_kind,
  input  wire logic [HANDLE_BITS-1:0] left_handle,
  input  wire logic                   right_valid,
  input  wire logic [TIME_BITS-1:0]   right_time,
  input  wire logic [2:0]             right_kind,
  input  wire logic [HANDLE_BITS-1:0] right_handle,
  output logic                        gt,
  output logic                        valid,
  output logic [TIME_BITS-1:0]        time_val,
  output logic [2:0]                  kind,
  output logic [HANDLE_BITS-1:0]      handle
);

  // An empty cell or one holding a strictly later time yields its place,
  // so equal times stay in arrival order.
  assign gt = !valid || (time_val > new_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.insert && gt) begin
      // A cell that takes its left neighbor's word takes its valid bit too,
      // so the empty cells past the tail stay empty.
      valid <= left_gt ? left_valid : 1'b1;
    end else if (cmd.pop) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && gt) begin
      if (left_gt) begin
        time_val <= left_time;
        kind     <= left_kind;
        handle   <= left_handle;
      end else begin
        time_val <= new_time;
        kind     <= new_kind;
        handle   <= new_handle;
      end
    end else if (cmd.pop) begin
      time_val <= right_time;
      kind     <= right_kind;
      handle   <= right_handle;
    end
  end

endmodule

`default_nettype wire

/* rtl/time_ordered_event_queue_core.sv */
// Every result word is registered; a request's first result word appears in the cycle
// after the request is accepted. A consume releases one due event per cycle while the
// result side accepts words, and gives a single word if nothing is due.
// Inserts and releases happen in the cell chain at once; the next request
// is taken once the last result word of the current one has been handed over.
// Reset clears the valid bit of every cell; the queue is empty after it.
`default_nettype none

module time_ordered_event_queue_core
  import toeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [31:0] time_stamp,
  input  wire logic [2:0]  event_kind,
  input  wire logic [15:0] event_handle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      out_time,
  output logic [2:0]       out_kind,
  output logic [15:0]      out_handle,
  output logic             last
);

  logic [TIME_BITS-1:0]   t_in;
  logic [HANDLE_BITS-1:0] h_in;

  logic                   c_gt     [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] c_valid;
  logic [TIME_BITS-1:0]   c_time   [QUEUE_DEPTH];
  logic [2:0]             c_kind   [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] c_handle [QUEUE_DEPTH];

  cell_cmd_t            cmd;
  state_t               state, state_next;
  logic [TIME_BITS-1:0] cons_time;
  logic [TIME_BITS-1:0] t_cmp;
  logic                 fire, post_fire, consume_fire, slot_free, release_step;
  logic                 head_due, next_due, full, load_out;

  logic [1:0]  status_next;
  logic [31:0] out_time_next;
  logic [2:0]  out_kind_next;
  logic [15:0] out_handle_next;
  logic        last_next;

  assign t_in = TIME_BITS'(time_stamp);
  assign h_in = HANDLE_BITS'(event_handle);

  // Cell chain: cell 0 is the head and holds the event with the earliest time.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                   l_gt;
    logic                   l_valid;
    logic [TIME_BITS-1:0]   l_time;
    logic [2:0]             l_kind;
    logic [HANDLE_BITS-1:0] l_handle;
    logic                   r_valid;
    logic [TIME_BITS-1:0]   r_time;
    logic [2:0]             r_kind;
    logic [HANDLE_BITS-1:0] r_handle;

    if (i == 0) begin : g_head
      assign l_gt     = 1'b0;
      assign l_valid  = 1'b0;
      assign l_time   = '0;
      assign l_kind   = '0;
      assign l_handle = '0;
    end else begin : g_mid
      assign l_gt     = c_gt[i-1];
      assign l_valid  = c_valid[i-1];
      assign l_time   = c_time[i-1];
      assign l_kind   = c_kind[i-1];
      assign l_handle = c_handle[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid  = 1'b0;
      assign r_time   = '0;
      assign r_kind   = '0;
      assign r_handle = '0;
    end else begin : g_body
      assign r_valid  = c_valid[i+1];
      assign r_time   = c_time[i+1];
      assign r_kind   = c_kind[i+1];
      assign r_handle = c_handle[i+1];
    end

    toeq_cell #(
      .TIME_BITS  (TIME_BITS),
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .new_time    (t_in),
      .new_kind    (event_kind),
      .new_handle  (h_in),
      .left_gt     (l_gt),
      .left_valid  (l_valid),
      .left_time   (l_time),
      .left_kind   (l_kind),
      .left_handle (l_handle),
      .right_valid (r_valid),
      .right_time  (r_time),
      .right_kind  (r_kind),
      .right_handle(r_handle),
      .gt          (c_gt[i]),
      .valid       (c_valid[i]),
      .time_val    (c_time[i]),
      .kind        (c_kind[i]),
      .handle      (c_handle[i])
    );
  end

  assign slot_free    = !out_valid || out_ready;
  assign fire         = in_valid && in_ready;
  assign post_fire    = fire && (req_type == REQ_POST);
  assign consume_fire = fire && (req_type == REQ_CONSUME);
  assign release_step = (state == S_RELEASE) && slot_free;
  assign full         = c_valid[QUEUE_DEPTH-1];

  // During a release run the time from the consume word is held in cons_time.
  assign t_cmp    = (state == S_IDLE) ? t_in : cons_time;
  assign head_due = c_valid[0] && (c_time[0] <= t_cmp);
  assign next_due = c_valid[1] && (c_time[1] <= t_cmp);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (consume_fire && head_due && next_due) begin
          state_next = S_RELEASE;
        end
      end
      S_RELEASE: begin
        if (slot_free && !next_due) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.insert = 1'b0;
    cmd.pop    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = slot_free;
        cmd.insert = post_fire && !full;
        cmd.pop    = consume_fire && head_due;
      end
      S_RELEASE: begin
        cmd.pop = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    load_out        = fire || release_step;
    status_next     = RESP_POSTED;
    out_time_next   = '0;
    out_kind_next   = '0;
    out_handle_next = '0;
    last_next       = 1'b1;
    if (post_fire) begin
      status_next = full ? RESP_FULL : RESP_POSTED;
    end else if (head_due) begin
      status_next     = RESP_RELEASED;
      out_time_next   = 32'(c_time[0]);
      out_kind_next   = c_kind[0];
      out_handle_next = 16'(c_handle[0]);
      last_next       = !next_due;
    end else begin
      status_next = RESP_NONE_DUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume_fire) begin
      cons_time <= t_in;
    end
    if (load_out) begin
      status     <= status_next;
      out_time   <= out_time_next;
      out_kind   <= out_kind_next;
      out_handle <= out_handle_next;
      last       <= last_next;
    end
  end

  // A release run only continues while the head holds an event and a result word is pending.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RELEASE) |-> (c_valid[0] && out_valid))
    else $error("release run without a head event or a pending result");

  // An insert never reaches a full chain.
  assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !full)
    else $error("insert into a full queue");

  // Occupied cells always form an unbroken run from the head.
  assert property (@(posedge clk) disable iff (rst)
    ((c_valid & (c_valid + 1'b1)) == '0))
    else $error("gap in the cell chain");

  // A consume that finds the head due always leaves a release word behind.
  assert property (@(posedge clk) disable iff (rst)
    (consume_fire && head_due) |=> (out_valid && (status == RESP_RELEASED)))
    else $error("due head not released");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the time-ordered event queue core.
`timescale 1ns / 100ps

module testbench;
  import toeq_pkg::*;

  localparam int EVENT_SLOTS = 16;
  localparam int RANDOM_REQUESTS = 330;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int MAX_IDLE = 18;

  typedef struct {
    logic [31:0] stamp;
    logic [2:0]  kind;
    logic [15:0] handle;
  } queued_event_t;

  typedef struct {
    resp_t       status;
    logic [31:0] stamp;
    logic [2:0]  kind;
    logic [15:0] handle;
    logic        last;
  } result_word_t;

  // Mirrors the sorted event store and keeps the result words still owed by the block.
  class due_event_model;
    queued_event_t held_events[$];
    result_word_t  awaited_words[$];
    int unsigned   mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_request(logic req, logic [31:0] stamp, logic [2:0] kind,
                               logic [15:0] handle);
      result_word_t  word;
      queued_event_t ev;
      int            pos;
      int            due;
      word.status = RESP_POSTED;
      word.stamp  = '0;
      word.kind   = '0;
      word.handle = '0;
      word.last   = 1'b1;
      if (req == REQ_POST) begin
        if (held_events.size() >= EVENT_SLOTS) begin
          word.status = RESP_FULL;
        end else begin
          // A new event goes behind every stored event with an equal or earlier time.
          pos = 0;
          while (pos < held_events.size() && held_events[pos].stamp <= stamp) pos++;
          ev.stamp  = stamp;
          ev.kind   = kind;
          ev.handle = handle;
          held_events.insert(pos, ev);
        end
        awaited_words.push_back(word);
      end else begin
        due = 0;
        while (due < held_events.size() && held_events[due].stamp <= stamp) due++;
        if (due == 0) begin
          word.status = RESP_NONE_DUE;
          awaited_words.push_back(word);
        end else begin
          for (int i = 0; i < due; i++) begin
            ev = held_events.pop_front();
            word.status = RESP_RELEASED;
            word.stamp  = ev.stamp;
            word.kind   = ev.kind;
            word.handle = ev.handle;
            word.last   = (i == due - 1);
            awaited_words.push_back(word);
          end
        end
      end
    endfunction

    function void check_word(result_word_t got);
      result_word_t want;
      if (awaited_words.size() == 0) begin
        $error("result word with status %0d arrived while none was expected", got.status);
        mismatches++;
        return;
      end
      want = awaited_words.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.stamp !== want.stamp) begin
        $error("out_time: expected %0h, got %0h", want.stamp, got.stamp);
        mismatches++;
      end
      if (got.kind !== want.kind) begin
        $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.handle !== want.handle) begin
        $error("out_handle: expected %0h, got %0h", want.handle, got.handle);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int words_owed();
      return awaited_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [31:0] time_stamp = '0;
  logic [2:0]  event_kind = '0;
  logic [15:0] event_handle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] out_time;
  logic [2:0]  out_kind;
  logic [15:0] out_handle;
  logic        last;

  due_event_model model;
  logic        calm_in = 1'b0;
  logic        calm_out = 1'b0;
  int unsigned stall_left = 0;
  int unsigned words_seen = 0;
  int unsigned cycle_count = 0;

  time_ordered_event_queue_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .time_stamp   (time_stamp),
    .event_kind   (event_kind),
    .event_handle (event_handle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_time     (out_time),
    .out_kind     (out_kind),
    .out_handle   (out_handle),
    .last         (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: a fresh stall is drawn after every accepted word, outside the calm phases.
  always @(posedge clk) begin
    result_word_t got;
    if (out_valid && out_ready) begin
      got.status = resp_t'(status);
      got.stamp  = out_time;
      got.kind   = out_kind;
      got.handle = out_handle;
      got.last   = last;
      model.check_word(got);
      words_seen++;
      calm_out = ((words_seen / 60) % 3) == 2;
      stall_left = calm_out ? 0 : $urandom_range(0, MAX_IDLE);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Starts and ends at a falling edge; valid stays high when no gap is drawn.
  task automatic send_request(input logic req, input logic [31:0] stamp,
                              input logic [2:0] kind, input logic [15:0] handle);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    time_stamp   <= stamp;
    event_kind   <= kind;
    event_handle <= handle;
    do @(posedge clk); while (!in_ready);
    model.note_request(req, stamp, kind, handle);
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (model.words_owed() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned now;
    int unsigned pick;
    logic [31:0] stamp;
    model = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty queue, field extremes, equal times, a full queue and
    // a consume that releases every stored event at once.
    send_request(REQ_CONSUME, 32'd100, 3'd0, 16'h0000);
    send_request(REQ_POST, 32'd5, 3'd0, 16'h0000);
    send_request(REQ_POST, 32'd5, 3'd7, 16'hFFFF);
    send_request(REQ_POST, 32'd0, 3'd3, 16'hAAAA);
    send_request(REQ_POST, 32'hFFFF_FFFF, 3'd4, 16'h5555);
    send_request(REQ_CONSUME, 32'd4, 3'd0, 16'h0000);
    send_request(REQ_CONSUME, 32'd3, 3'd0, 16'h0000);
    for (int n = 0; n < 13; n++) begin
      send_request(REQ_POST, 32'd5 + (n % 4), 3'(n), 16'h1230 + 16'(n));
    end
    send_request(REQ_POST, 32'd2, 3'd1, 16'hBEEF);
    send_request(REQ_CONSUME, 32'hFFFF_FFFF, 3'd0, 16'h0000);

    // Random part: times cluster around a moving current time so that equal
    // times, partial releases and a full queue come up often.
    now = $urandom_range(0, 1000);
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm_in = ((n / 40) % 3) == 1;
      if (n == RANDOM_REQUESTS / 2) wait_until_drained();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_request(REQ_POST, now + $urandom_range(0, 40), 3'($urandom),
                     16'($urandom));
      end else if (pick < 55) begin
        send_request(REQ_POST, $urandom, 3'($urandom), 16'($urandom));
      end else begin
        if (pick < 92) stamp = now + $urandom_range(0, 40);
        else if (pick < 96) stamp = 32'd0;
        else stamp = 32'hFFFF_FFFF;
        send_request(REQ_CONSUME, stamp, 3'($urandom), 16'($urandom));
        now = now + $urandom_range(0, 20);
      end
    end

    wait_until_drained();
    repeat (20) @(negedge clk);
    if (model.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
